/* rtl/fpha_pkg.sv */
// Package for the fit-policy hole allocator.
// Field widths, command/status/register codes, controller states and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package fpha_pkg;

	localparam int MAX_HOLES_DEF = 16;
	localparam int SIZE_BITS_DEF = 16;

	localparam int SLOT_W     = 4;
	localparam int REQ_W      = 16;
	localparam int STATUS_W   = 2;
	localparam int HOLE_W     = 4;
	localparam int LEFT_W     = 16;
	localparam int TOTAL_W    = 20;
	localparam int MODE_W     = 2;
	localparam int INUSE_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [INUSE_W-1:0] INUSE_RST = INUSE_W'(16);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_mode_t;

	typedef enum logic [0:0] {
		CMD_LOAD  = 1'b0,
		CMD_ALLOC = 1'b1
	} command_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_LOADED  = 2'd0,
		RES_GRANTED = 2'd1,
		RES_REFUSED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT_MODE     = 1'b0,
		CFG_HOLES_IN_USE = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_write;
		logic issue;
		logic emit;
	} fpha_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} fpha_sts_t;

endpackage

`default_nettype wire

/* rtl/fpha_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fpha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/fpha_ctrl.sv */
// Controller state machine for the hole allocator.
// Depends on fpha_pkg; drives the datapath through fpha_cmd_t.
`default_nettype none

module fpha_ctrl import fpha_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_kind,
	output logic           in_ready,
	input  wire fpha_sts_t sts,
	output fpha_cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (in_kind == CMD_LOAD) ? S_LOAD : S_SCAN;
				end
			end
			S_LOAD: begin
				cmd.load_write = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_RESULT;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/fpha_datapath.sv */
// Datapath: config registers, hole table, scan/compare stage, result register.
// Depends on fpha_pkg and fpha_ram; steered by fpha_ctrl.
`default_nettype none

module fpha_datapath import fpha_pkg::*; #(
	parameter int MAX_HOLES = MAX_HOLES_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire fpha_cmd_t             cmd,
	output fpha_sts_t                  sts,
	input  wire logic                  in_kind,
	input  wire logic [SLOT_W-1:0]     in_slot,
	input  wire logic [REQ_W-1:0]      in_size,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic      [STATUS_W-1:0]   out_status,
	output logic      [HOLE_W-1:0]     out_hole,
	output logic      [LEFT_W-1:0]     out_left,
	output logic      [TOTAL_W-1:0]    out_total
);

	localparam int AW = $clog2(MAX_HOLES);
	localparam int SW = SIZE_BITS + INUSE_W;

	logic [MODE_W-1:0]    fit_mode_q;
	logic [INUSE_W-1:0]   holes_in_use_q;
	logic [INUSE_W-1:0]   scan_n;
	logic                 halted_q;
	logic [MAX_HOLES-1:0] hole_vld_q;

	logic                 is_load_q;
	logic                 req_live_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 load_ok;

	logic [INUSE_W-1:0]   cnt_q;
	logic [AW-1:0]        raddr;
	logic [SIZE_BITS-1:0] rdata;

	logic                 eval_s1;
	logic                 vld_s1;
	logic [INUSE_W-1:0]   idx_s1;

	logic [SIZE_BITS-1:0] h;
	logic [SIZE_BITS-1:0] left;
	logic                 fits;
	logic                 take;

	logic [SW-1:0]        sum_q;
	logic                 found_q;
	logic [INUSE_W-1:0]   pick_q;
	logic [SIZE_BITS-1:0] pick_left_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata;

	logic [SW-1:0]        total_raw;
	logic [TOTAL_W-1:0]   total_sat;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [HOLE_W-1:0]    out_hole_q;
	logic [LEFT_W-1:0]    out_left_q;
	logic [TOTAL_W-1:0]   out_total_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q     <= FIT_FIRST;
			holes_in_use_q <= INUSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FIT_MODE:     fit_mode_q     <= cfg_wdata[MODE_W-1:0];
				CFG_HOLES_IN_USE: holes_in_use_q <= cfg_wdata[INUSE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		scan_n = (int'(holes_in_use_q) > MAX_HOLES) ? INUSE_W'(MAX_HOLES) : holes_in_use_q;
	end

	// beat capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_load_q  <= (in_kind == CMD_LOAD);
			req_live_q <= (in_kind == CMD_ALLOC) && !halted_q;
			slot_q     <= in_slot;
			size_q     <= SIZE_BITS'(in_size);
		end
	end

	assign load_ok = int'(slot_q) < MAX_HOLES;

	// hole table
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(pick_q);
		ram_wdata = pick_left_q;
		if (cmd.load_write) begin
			ram_we    = load_ok;
			ram_waddr = AW'(slot_q);
			ram_wdata = size_q;
		end else if (cmd.emit) begin
			ram_we = found_q;
		end
	end

	assign raddr = AW'(cnt_q);

	fpha_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_HOLES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_vld_q <= '0;
			halted_q   <= 1'b0;
		end else begin
			if (ram_we) begin
				hole_vld_q[ram_waddr] <= 1'b1;
			end
			if (cmd.emit) begin
				if (is_load_q) begin
					halted_q <= 1'b0;
				end else if (!found_q) begin
					halted_q <= 1'b1;
				end
			end
		end
	end

	// scan: one read issued per cycle, compared in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			eval_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			eval_s1 <= cmd.issue;
			if (cmd.capture) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (eval_s1 && take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= hole_vld_q[raddr];
		idx_s1 <= cnt_q;
	end

	assign sts.scan_done = (cnt_q == scan_n);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		h    = vld_s1 ? rdata : '0;
		left = h - size_q;
		fits = req_live_q && (h >= size_q);
		take = fits && (!found_q
			|| ((fit_mode_q == FIT_BEST) && (left < pick_left_q))
			|| ((fit_mode_q == FIT_WORST) && (left > pick_left_q)));
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sum_q <= '0;
		end else if (eval_s1) begin
			sum_q <= sum_q + SW'(h);
			if (take) begin
				pick_q      <= idx_s1;
				pick_left_q <= left;
			end
		end
	end

	// result
	always_comb begin
		total_raw = (!is_load_q && found_q) ? sum_q - SW'(size_q) : sum_q;
		total_sat = (64'(total_raw) > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(total_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_total_q <= total_sat;
			if (is_load_q) begin
				out_status_q <= RES_LOADED;
				out_hole_q   <= '0;
				out_left_q   <= '0;
			end else if (found_q) begin
				out_status_q <= RES_GRANTED;
				out_hole_q   <= HOLE_W'(pick_q);
				out_left_q   <= LEFT_W'(pick_left_q);
			end else begin
				out_status_q <= RES_REFUSED;
				out_hole_q   <= '0;
				out_left_q   <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_hole   = out_hole_q;
	assign out_left   = out_left_q;
	assign out_total  = out_total_q;

endmodule

`default_nettype wire

/* rtl/fit_policy_hole_allocator.sv */
// Top level of the fit-policy hole allocator (first, best or worst fit).
// Depends on fpha_pkg, fpha_ctrl, fpha_datapath (and fpha_ram below it).
//
//  channel   signals                         payload
//  --------  ------------------------------  ----------------------------------
//  s_axis    tvalid/tready/tdata/tuser       tuser: command; tdata: slot, size
//  m_axis    tvalid/tready/tdata/tuser       tuser: status; tdata: hole, left,
//                                            free total
//  cfg       cfg_we/cfg_addr/cfg_wdata       0 fit_mode, 1 holes_in_use
//
// A request scans N table entries between the accepted beat and the result
// register, a load first writes its slot, with N = holes_in_use capped at
// MAX_HOLES: the table is read one entry a cycle through the single RAM port.
// One beat is in work at a time; a new beat is taken while the previous result
// still waits on m_axis, and stalls in its result state until m_axis frees.
// Reset clears the table (valid bits), sets first fit and sixteen holes.
`default_nettype none

module fit_policy_hole_allocator import fpha_pkg::*; #(
	parameter int MAX_HOLES = MAX_HOLES_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [23:0]           s_axis_tdata,  // hole_slot[3:0], size_value[19:4]
	input  wire logic [0:0]            s_axis_tuser,  // command
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [39:0]           m_axis_tdata,  // chosen_hole[3:0], hole_left[19:4],
	                                                  // free_total[39:20]
	output logic      [STATUS_W-1:0]   m_axis_tuser,  // status
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	fpha_cmd_t cmd;
	fpha_sts_t sts;

	logic [HOLE_W-1:0]  out_hole;
	logic [LEFT_W-1:0]  out_left;
	logic [TOTAL_W-1:0] out_total;

	fpha_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_kind (s_axis_tuser[0]),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fpha_datapath #(
		.MAX_HOLES(MAX_HOLES),
		.SIZE_BITS(SIZE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (s_axis_tuser[0]),
		.in_slot   (s_axis_tdata[3:0]),
		.in_size   (s_axis_tdata[19:4]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_status(m_axis_tuser),
		.out_hole  (out_hole),
		.out_left  (out_left),
		.out_total (out_total)
	);

	assign m_axis_tdata = {out_total, out_left, out_hole};

endmodule

`default_nettype wire

/* tb/fpha_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the fit-policy hole allocator: tracks the config port and the
// hole table, predicts every result beat and compares it field by field.
// Depends on fpha_pkg.
module fpha_checker import fpha_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // hole_slot[3:0], size_value[19:4]
	input  logic [0:0]            s_axis_tuser,  // command
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [39:0]           m_axis_tdata,  // chosen_hole[3:0], hole_left[19:4],
	                                             // free_total[39:20]
	input  logic [STATUS_W-1:0]   m_axis_tuser,  // status
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    outstanding,
	output int                    fail_count
);

	localparam int DUE_DEPTH = 4;

	typedef struct packed {
		status_t            status;
		logic [HOLE_W-1:0]  hole;
		logic [LEFT_W-1:0]  left;
		logic [TOTAL_W-1:0] total;
	} outcome_t;

	logic [REQ_W-1:0]   hole_tbl [MAX_HOLES_DEF];
	logic               refusing;
	logic [MODE_W-1:0]  mode;
	logic [INUSE_W-1:0] in_use;
	outcome_t           outcomes_due [DUE_DEPTH];
	logic [1:0]         due_head;
	logic [1:0]         due_tail;
	int                 due_cnt;

	function automatic logic [TOTAL_W-1:0] free_space(int n);
		int sum;
		sum = 0;
		for (int i = 0; i < n; i++)
			sum += hole_tbl[i];
		return (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
	endfunction

	// Applies one beat to the shadow table and returns the result it should give.
	function automatic outcome_t hole_outcome(command_t cmd, logic [SLOT_W-1:0] slot,
			logic [REQ_W-1:0] size);
		outcome_t o;
		int n;
		bit found;
		int pick;
		logic [REQ_W-1:0] pick_left;
		logic [REQ_W-1:0] left;
		o = '0;
		found = 1'b0;
		pick = 0;
		pick_left = '0;
		n = (in_use > MAX_HOLES_DEF) ? MAX_HOLES_DEF : int'(in_use);
		if (cmd == CMD_LOAD) begin
			hole_tbl[slot] = size;
			refusing = 1'b0;
			o.status = RES_LOADED;
		end else begin
			if (!refusing) begin
				for (int i = 0; i < n; i++) begin
					if (hole_tbl[i] < size)
						continue;
					left = hole_tbl[i] - size;
					if (!found || (mode == FIT_BEST && left < pick_left) ||
							(mode == FIT_WORST && left > pick_left)) begin
						pick = i;
						pick_left = left;
					end
					found = 1'b1;
					// first fit, and the spare code, stop at the first hole that fits
					if (mode != FIT_BEST && mode != FIT_WORST)
						break;
				end
			end
			if (found) begin
				hole_tbl[pick] = pick_left;
				o.status = RES_GRANTED;
				o.hole = HOLE_W'(pick);
				o.left = pick_left;
			end else begin
				refusing = 1'b1;
				o.status = RES_REFUSED;
			end
		end
		o.total = free_space(n);
		return o;
	endfunction

	task automatic check_field(string field, logic [TOTAL_W-1:0] want_v,
			logic [TOTAL_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_HOLES_DEF; i++)
				hole_tbl[i] = '0;
			refusing = 1'b0;
			mode = FIT_FIRST;
			in_use = INUSE_RST;
			due_head = '0;
			due_tail = '0;
			due_cnt = 0;
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_FIT_MODE)
					mode = cfg_wdata[MODE_W-1:0];
				else if (cfg_addr == CFG_HOLES_IN_USE)
					in_use = cfg_wdata[INUSE_W-1:0];
			end
			// output side first: a result beat never belongs to this edge's input beat
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_cnt == 0) begin
					$error("result beat with nothing expected: status %0d, tdata %h",
						m_axis_tuser, m_axis_tdata);
					fail_count++;
				end else begin
					want = outcomes_due[due_head];
					due_head = due_head + 2'd1;
					due_cnt--;
					check_field("status", TOTAL_W'(want.status), TOTAL_W'(m_axis_tuser));
					check_field("chosen_hole", TOTAL_W'(want.hole),
						TOTAL_W'(m_axis_tdata[3:0]));
					check_field("hole_left", TOTAL_W'(want.left),
						TOTAL_W'(m_axis_tdata[19:4]));
					check_field("free_total", want.total, m_axis_tdata[39:20]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (due_cnt == DUE_DEPTH) begin
					$error("input beat with %0d results still owed", due_cnt);
					fail_count++;
				end else begin
					outcomes_due[due_tail] = hole_outcome(command_t'(s_axis_tuser),
						s_axis_tdata[3:0], s_axis_tdata[19:4]);
					due_tail = due_tail + 2'd1;
					due_cnt++;
				end
			end
			outstanding <= due_cnt;
		end
	end

endmodule

/* tb/tb_fit_policy_hole_allocator.sv */
`timescale 1ns / 100ps
// Testbench top for the fit-policy hole allocator: clock, reset, register writes
// and load/request beats with random idling on both channels.
// Depends on fpha_pkg, fpha_checker and the allocator RTL.
module tb_fit_policy_hole_allocator;
	import fpha_pkg::*;

	localparam int RAND_ITEMS    = 750;
	localparam int ALL_ITEMS     = RAND_ITEMS + 25;
	localparam int N_PHASES      = 10;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;

	localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;
	localparam logic [REQ_W-1:0]  SIZE_MAX  = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	wire                   s_axis_tready;
	logic [23:0]           s_axis_tdata;  // hole_slot[3:0], size_value[19:4]
	logic [0:0]            s_axis_tuser;  // command
	wire                   m_axis_tvalid;
	logic                  m_axis_tready;
	wire  [39:0]           m_axis_tdata;  // chosen_hole[3:0], hole_left[19:4],
	                                      // free_total[39:20]
	wire  [STATUS_W-1:0]   m_axis_tuser;  // status
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int outstanding;
	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;
	int sent;
	int cycles = 0;

	fit_policy_hole_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	fpha_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.outstanding   (outstanding),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_beat(command_t cmd, logic [SLOT_W-1:0] slot, logic [REQ_W-1:0] size);
		if (sent < ALL_ITEMS / 3) begin
			send_idle_pct = 36;
			recv_idle_pct = 68;
		end else if (sent < 2 * ALL_ITEMS / 3) begin
			send_idle_pct = 68;
			recv_idle_pct = 36;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {4'b0, size, slot};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_policy(logic [MODE_W-1:0] mode, logic [INUSE_W-1:0] in_use);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_FIT_MODE;
		cfg_wdata <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_addr  <= CFG_HOLES_IN_USE;
		cfg_wdata <= in_use;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [REQ_W-1:0] rand_size();
		case ($urandom_range(9))
			0:       return '0;
			1, 2, 3: return REQ_W'($urandom_range(255));
			4, 5, 6: return REQ_W'($urandom_range(4095));
			default: return REQ_W'($urandom());
		endcase
	endfunction

	// mostly slots inside the scanned window, now and then anywhere
	function automatic logic [SLOT_W-1:0] pick_slot(logic [INUSE_W-1:0] in_use);
		int n;
		n = (in_use > MAX_HOLES_DEF) ? MAX_HOLES_DEF : int'(in_use);
		if (n == 0 || $urandom_range(4) == 0)
			return SLOT_W'($urandom_range(15));
		return SLOT_W'($urandom_range(n - 1));
	endfunction

	task automatic random_phase(logic [MODE_W-1:0] mode, logic [INUSE_W-1:0] in_use,
			int items);
		int done;
		int n_load;
		int n_req;
		done = 0;
		drain();
		set_policy(mode, in_use);
		while (done < items) begin
			if ($urandom_range(19) == 0) begin
				for (int s = 0; s < MAX_HOLES_DEF; s++)
					send_beat(CMD_LOAD, SLOT_W'(s), SIZE_MAX);
				done += MAX_HOLES_DEF;
			end else begin
				n_load = $urandom_range(1, 5);
				for (int k = 0; k < n_load; k++)
					send_beat(CMD_LOAD, pick_slot(in_use), rand_size());
				done += n_load;
			end
			n_req = $urandom_range(1, 8);
			for (int k = 0; k < n_req; k++)
				send_beat(CMD_ALLOC, SLOT_W'($urandom_range(15)),
					rand_size() >> $urandom_range(3));
			done += n_req;
			if ($urandom_range(9) == 0) begin
				send_beat(command_t'($urandom_range(1)), SLOT_W'($urandom_range(15)),
					REQ_W'($urandom()));
				done++;
			end
		end
	endtask

	initial begin
		logic [MODE_W-1:0]  phase_mode  [N_PHASES];
		logic [INUSE_W-1:0] phase_inuse [N_PHASES];
		phase_mode  = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_SPARE, FIT_BEST,
			FIT_WORST, FIT_FIRST, FIT_BEST, FIT_WORST, FIT_FIRST};
		phase_inuse = '{5'd16, 5'd5, 5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd16, 5'd9, 5'd12};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_LOAD;
		cfg_we        = 1'b0;
		cfg_addr      = CFG_FIT_MODE;
		cfg_wdata     = '0;
		send_idle_pct = 36;
		recv_idle_pct = 68;
		sent          = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_policy(FIT_BEST, 5'd16);
		send_beat(CMD_ALLOC, 4'hF, '0);       // zero request fits an empty hole
		send_beat(CMD_ALLOC, '0, 16'd1);      // nothing fits, block halts
		send_beat(CMD_ALLOC, '0, '0);         // refused while halted
		send_beat(CMD_LOAD, 4'hF, SIZE_MAX);  // load clears halt
		send_beat(CMD_LOAD, '0, SIZE_MAX);
		send_beat(CMD_LOAD, 4'd7, 16'd100);
		send_beat(CMD_LOAD, 4'd3, 16'd300);
		send_beat(CMD_ALLOC, '0, 16'd100);    // exact fit in slot 7
		send_beat(CMD_ALLOC, '0, SIZE_MAX);   // tie on leftover, lowest index wins
		drain();
		set_policy(FIT_WORST, 5'd16);
		send_beat(CMD_ALLOC, '0, 16'd1);
		send_beat(CMD_ALLOC, 4'hA, 16'd250);
		drain();
		set_policy(FIT_SPARE, 5'd31);         // spare mode as first fit, count saturates
		send_beat(CMD_ALLOC, '0, 16'd10);
		send_beat(CMD_LOAD, 4'hC, 16'h5555);
		send_beat(CMD_ALLOC, 4'h5, 16'hAAAA);
		drain();
		set_policy(FIT_FIRST, 5'd0);          // empty scan window
		send_beat(CMD_ALLOC, '0, '0);
		send_beat(CMD_LOAD, 4'd2, 16'd5);
		drain();
		set_policy(FIT_BEST, 5'd1);
		send_beat(CMD_ALLOC, '0, '0);

		for (int p = 0; p < N_PHASES; p++)
			random_phase(phase_mode[p], phase_inuse[p], RAND_ITEMS / N_PHASES);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/fpha_pkg.sv
rtl/fpha_ram.sv
rtl/fpha_ctrl.sv
rtl/fpha_datapath.sv
rtl/fit_policy_hole_allocator.sv
tb/fpha_checker.sv
tb/tb_fit_policy_hole_allocator.sv
